// ----- hdl/zfpk_pkg.sv -----
// ----------------------------------------------------------------------------
// zfpk_pkg
// Shared types and constants for the zero/FF bit-code packer.
// ----------------------------------------------------------------------------
`default_nettype none

package zfpk_pkg;

    // Default depth of the word queue between front and back (power of two).
    localparam int ZFPK_QUEUE_DEPTH = 4;

    localparam logic [0:0] FUNC_DATA = 1'b0;
    localparam logic [0:0] FUNC_END  = 1'b1;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Codes, left-aligned in 9 bits.
    localparam logic [8:0] CODE_ZERO = 9'b00_0000000;  // 0x00 -> 00
    localparam logic [8:0] CODE_ONES = 9'b01_0000000;  // 0xFF -> 01
    localparam logic [8:0] CODE_TERM = 9'b1_0000_0000; // terminator

    localparam logic [4:0] LEN_SHORT = 5'd2;
    localparam logic [4:0] LEN_LONG  = 5'd9;

    // One or two finished output words produced by one input item.
    typedef struct packed {
        logic       two_bytes;  // byte1 valid
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;       // byte1 is the final word of the stream
    } zfpk_entry_t;

endpackage

`default_nettype wire

// ----- hdl/zfpk_front.sv -----
// ----------------------------------------------------------------------------
// zfpk_front
// Accepts items, codes each byte and packs the bits; pushes finished words.
// ----------------------------------------------------------------------------
`default_nettype none

module zfpk_front
    import zfpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [0:0]  func,
    input  wire logic [7:0]  data,
    input  wire logic        q_full,
    output logic             q_push,
    output zfpk_entry_t      q_entry
);

    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  fill_reg, fill_next;
    logic [8:0]  code;
    logic [4:0]  len;
    logic [4:0]  total;
    logic [4:0]  total_m8;
    logic [15:0] win;
    logic        accept;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    always_comb
    begin
        if (func == FUNC_END)
        begin
            code = CODE_TERM;
            len  = LEN_LONG;
        end
        else if (data == BYTE_ZERO)
        begin
            code = CODE_ZERO;
            len  = LEN_SHORT;
        end
        else if (data == BYTE_ONES)
        begin
            code = CODE_ONES;
            len  = LEN_SHORT;
        end
        else
        begin
            code = {1'b1, data};
            len  = LEN_LONG;
        end
    end

    assign win      = {partial_reg, 8'h00} | ({code, 7'b0} >> fill_reg);
    assign total    = {2'b00, fill_reg} + len;
    assign total_m8 = total - 5'd8;

    always_comb
    begin
        q_push          = 1'b0;
        q_entry.two_bytes = 1'b0;
        q_entry.byte0   = win[15:8];
        q_entry.byte1   = win[7:0];
        q_entry.last    = 1'b0;
        partial_next    = partial_reg;
        fill_next       = fill_reg;
        if (accept)
        begin
            if (func == FUNC_END)
            begin
                // fill + 9 is 9..16 bits: always two words, second is last
                q_push            = 1'b1;
                q_entry.two_bytes = 1'b1;
                q_entry.last      = 1'b1;
                partial_next      = 8'h00;
                fill_next         = 3'd0;
            end
            else if (total >= 5'd16)
            begin
                q_push            = 1'b1;
                q_entry.two_bytes = 1'b1;
                partial_next      = 8'h00;
                fill_next         = 3'd0;
            end
            else if (total >= 5'd8)
            begin
                q_push       = 1'b1;
                partial_next = win[7:0];
                fill_next    = total_m8[2:0];
            end
            else
            begin
                partial_next = win[15:8];
                fill_next    = total[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 8'h00;
            fill_reg    <= 3'd0;
        end
        else
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/zfpk_queue.sv -----
// ----------------------------------------------------------------------------
// zfpk_queue
// Small FIFO of packed word entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module zfpk_queue
    import zfpk_pkg::*;
#(
    parameter int DEPTH = ZFPK_QUEUE_DEPTH  // power of two, >= 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire zfpk_entry_t  push_entry,
    input  wire logic         pop,
    output zfpk_entry_t       head,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    zfpk_entry_t       store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/zfpk_back.sv -----
// ----------------------------------------------------------------------------
// zfpk_back
// Splits queue entries into single words and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zfpk_back
    import zfpk_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire zfpk_entry_t  head,
    input  wire logic         empty,
    output logic              pop,
    output logic              byte_valid,
    input  wire logic         byte_stall,
    output logic [7:0]        packed_byte,
    output logic              last
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_last_reg, pend_last_next;
    logic       load;

    assign load        = !out_valid_reg || !byte_stall;
    assign byte_valid  = out_valid_reg;
    assign packed_byte = out_byte_reg;
    assign last        = out_last_reg;

    always_comb
    begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        pend_last_next = pend_last_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = pend_last_reg;
                pend_next      = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_byte_next  = head.byte0;
                out_last_next  = 1'b0;
                pend_next      = head.two_bytes;
                pend_byte_next = head.byte1;
                pend_last_next = head.last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
    end

endmodule

`default_nettype wire

// ----- hdl/zero_ff_bit_code_packer_top.sv -----
// ----------------------------------------------------------------------------
// zero_ff_bit_code_packer_top
// Codes raw bytes (0x00 -> 00, 0xFF -> 01, else 1 + byte) into a packed
// bit stream, MSB first, and emits each word as it fills.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall, func, data): func = 0 codes the
//   byte in data, func = 1 ends the stream (terminator 1 + eight zeros,
//   partial word flushed zero-padded, packer returns to empty).
//   Word channel (byte_valid / byte_stall, packed_byte, last): last marks
//   the final word of an end-of-stream item. An end item always gives two
//   words; a data item gives zero, one or two.
//   Throughput: one item per cycle while the word side keeps up; words
//   leave at one word per cycle while byte_stall is low, so items giving
//   two words drain through the entry queue (QUEUE_DEPTH entries).
//   Path: with the queue and output register empty, the first word of an
//   accepted item is written into the queue, then loaded into the output
//   register; a second word waits in the pending register and follows it.
//   Stall: byte_stall holds the output register; the queue absorbs items
//   until full, then item_stall rises. Nothing is dropped.
//   Reset: clears the bit packer, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_ff_bit_code_packer_top
    import zfpk_pkg::*;
#(
    parameter int QUEUE_DEPTH = ZFPK_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item side
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [0:0]  func,
    input  wire logic [7:0]  data,
    // word side
    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       packed_byte,
    output logic             last
);

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    zfpk_entry_t q_in;
    zfpk_entry_t q_head;

    // Front: classify item, pack bits, push finished words.
    zfpk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .data       (data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    // Decoupling queue.
    zfpk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // Back: one word per cycle into the output register while byte_stall is low.
    zfpk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .packed_byte (packed_byte),
        .last        (last)
    );

    // An accepted end item always produces a queue entry.
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && func == FUNC_END) |-> q_push)
        else $error("end item accepted without queue push");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
